[rtl/core/ffsa_pkg.sv]
package ffsa_pkg;

   localparam logic [1:0] KIND_ALLOC   = 2'd0;
   localparam logic [1:0] KIND_FREE    = 2'd1;
   localparam logic [1:0] KIND_REALLOC = 2'd2;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_HEAP_FULL  = 3'd1;
   localparam logic [2:0] STATUS_ZERO_SIZE  = 3'd2;
   localparam logic [2:0] STATUS_TABLE_FULL = 3'd3;
   localparam logic [2:0] STATUS_UNKNOWN    = 3'd4;

   localparam logic [31:0] HEAP_LIMIT_RESET = 32'd65536;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [31:0] size;
   } req_type;

   typedef struct packed {
      logic [31:0] result_address;
      logic [2:0]  status;
      logic [31:0] copy_from;
      logic [31:0] copy_bytes;
   } rsp_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] size;
      logic        free;
   } seg_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_LOAD,
      CELL_MARK,
      CELL_MERGE,
      CELL_CLOSE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      seg_type     data;
   } cell_cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_FREE1,
      S_FREE2,
      S_MERGE,
      S_CLOSE,
      S_DONE
   } ctrl_state_type;

endpackage

[rtl/core/first_fit_segment_allocator_core.sv]
// One transaction at a time: the next request is taken in the cycle after the
// result strobe at the earliest. A free of a known segment, also inside a moving
// realloc, adds the states FREE1, FREE2 and MERGE, and CLOSE once per neighbour
// merged. Each request runs a scan that rotates the whole ring of segment cells
// once past the head controller. The result strobe lasts one cycle and cannot
// be stalled. Synchronous reset empties the table and restores heap_limit.
module first_fit_segment_allocator_core #(
   parameter int MAX_SEGMENTS = 64,
   parameter int HEADER_BYTES = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffsa_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ffsa_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import ffsa_pkg::*;

   localparam int IW = $clog2(MAX_SEGMENTS);

   logic [31:0]  heap_limit_ff;
   seg_type      segs [MAX_SEGMENTS];
   cell_cmd_type cell_cmd;
   logic [IW-1:0] cell_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff <= HEAP_LIMIT_RESET;
      end else if (psel && penable && pwrite && !paddr[2]) begin
         heap_limit_ff <= pwdata;
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : heap_limit_ff;

   for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
      localparam int NEXT = (k + 1) % MAX_SEGMENTS;
      ffsa_cell #(
         .MAX_SEGMENTS(MAX_SEGMENTS),
         .INDEX(k)
      ) u_cell (
         .clock(clock),
         .cmd(cell_cmd),
         .idx(cell_idx),
         .next_seg(segs[NEXT]),
         .seg(segs[k])
      );
   end

   ffsa_ctrl #(
      .MAX_SEGMENTS(MAX_SEGMENTS),
      .HEADER_BYTES(HEADER_BYTES)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .heap_limit(heap_limit_ff),
      .head0(segs[0]),
      .head1(segs[1]),
      .cell_cmd(cell_cmd),
      .cell_idx(cell_idx),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

endmodule

[rtl/core/ffsa_cell.sv]
module ffsa_cell #(
   parameter int MAX_SEGMENTS = 64,
   parameter int INDEX = 0
) (
   input  logic                            clock,
   input  ffsa_pkg::cell_cmd_type          cmd,
   input  logic [$clog2(MAX_SEGMENTS)-1:0] idx,
   input  ffsa_pkg::seg_type               next_seg,
   output ffsa_pkg::seg_type               seg
);
   import ffsa_pkg::*;

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   seg_type seg_ff;
   seg_type seg_in;
   logic    hit;
   logic    at_or_after;

   assign hit = (idx == MY_IDX);
   assign at_or_after = (MY_IDX >= idx);

   always_comb begin
      seg_in = seg_ff;
      case (cmd.op)
         CELL_HOLD: begin
            seg_in = seg_ff;
         end
         CELL_ROTATE: begin
            seg_in = next_seg;
         end
         CELL_LOAD: begin
            if (hit) begin
               seg_in = cmd.data;
            end
         end
         CELL_MARK: begin
            if (hit) begin
               seg_in.free = cmd.data.free;
            end
         end
         CELL_MERGE: begin
            if (hit) begin
               seg_in.size = cmd.data.size;
               seg_in.free = 1'b1;
            end
         end
         CELL_CLOSE: begin
            if (at_or_after) begin
               seg_in = next_seg;
            end
         end
         default: begin
            seg_in = seg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   assign seg = seg_ff;

endmodule

[rtl/core/ffsa_ctrl.sv]
module ffsa_ctrl #(
   parameter int MAX_SEGMENTS = 64,
   parameter int HEADER_BYTES = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  ffsa_pkg::req_type               req_data,
   input  logic [31:0]                     heap_limit,
   input  ffsa_pkg::seg_type               head0,
   input  ffsa_pkg::seg_type               head1,
   output ffsa_pkg::cell_cmd_type          cell_cmd,
   output logic [$clog2(MAX_SEGMENTS)-1:0] cell_idx,
   output logic                            rsp_strobe,
   output ffsa_pkg::rsp_type               rsp_data
);
   import ffsa_pkg::*;

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SEGMENTS);
   localparam logic [CW-1:0] LAST_STEP = CW'(MAX_SEGMENTS - 1);
   localparam logic [31:0] HDR = 32'(HEADER_BYTES);

   ctrl_state_type state_ff, state_in;
   logic [CW-1:0]  step_ff, step_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [31:0]    top_ff, top_in;
   req_type        req_ff, req_in;
   rsp_type        rsp_ff, rsp_in;
   logic           l_found_ff, l_found_in;
   logic [IW-1:0]  l_idx_ff, l_idx_in;
   logic [31:0]    l_size_ff, l_size_in;
   logic           l_pf_ff, l_pf_in;
   logic           l_nf_ff, l_nf_in;
   logic [31:0]    pre_size_ff, pre_size_in;
   logic [31:0]    nxt_size_ff, nxt_size_in;
   logic           prev_free_ff, prev_free_in;
   logic [31:0]    prev_size_ff, prev_size_in;
   logic           f_found_ff, f_found_in;
   logic [IW-1:0]  f_idx_ff, f_idx_in;
   logic [31:0]    f_start_ff, f_start_in;
   logic [31:0]    acc_ff, acc_in;
   logic [1:0]     ndel_ff, ndel_in;
   logic [IW-1:0]  del_idx_ff, del_idx_in;

   logic           entry_valid;
   logic           next_valid;
   logic           alloc_req;
   logic           free_req;
   logic           re_req;
   logic           need_alloc;
   logic           a_ok;
   logic [2:0]     a_status;
   logic [31:0]    a_addr;
   logic [33:0]    heap_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         top_ff <= '0;
         ndel_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff <= top_in;
         ndel_ff <= ndel_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      l_found_ff <= l_found_in;
      l_idx_ff <= l_idx_in;
      l_size_ff <= l_size_in;
      l_pf_ff <= l_pf_in;
      l_nf_ff <= l_nf_in;
      pre_size_ff <= pre_size_in;
      nxt_size_ff <= nxt_size_in;
      prev_free_ff <= prev_free_in;
      prev_size_ff <= prev_size_in;
      f_found_ff <= f_found_in;
      f_idx_ff <= f_idx_in;
      f_start_ff <= f_start_in;
      acc_ff <= acc_in;
      del_idx_ff <= del_idx_in;
   end

   assign entry_valid = (step_ff < count_ff);
   assign next_valid = ({1'b0, step_ff} + {{CW{1'b0}}, 1'b1}) < {1'b0, count_ff};
   assign heap_end = {2'b00, top_ff} + {2'b00, HDR} + {2'b00, req_ff.size};

   assign alloc_req = (req_ff.kind == KIND_ALLOC)
                      || ((req_ff.kind == KIND_REALLOC) && (req_ff.address == '0));
   assign free_req = (req_ff.kind == KIND_FREE)
                     || ((req_ff.kind == KIND_REALLOC) && (req_ff.address != '0)
                         && (req_ff.size == '0));
   assign re_req = (req_ff.kind == KIND_REALLOC) && (req_ff.address != '0)
                   && (req_ff.size != '0);
   assign need_alloc = alloc_req || (re_req && l_found_ff && (l_size_ff < req_ff.size));

   always_comb begin
      a_ok = 1'b0;
      a_status = STATUS_OK;
      a_addr = '0;
      if (req_ff.size == '0) begin
         a_status = STATUS_ZERO_SIZE;
      end else if (f_found_ff) begin
         a_ok = 1'b1;
         a_addr = f_start_ff + HDR;
      end else if (count_ff >= MAX_COUNT) begin
         a_status = STATUS_TABLE_FULL;
      end else if (heap_end > {2'b00, heap_limit}) begin
         a_status = STATUS_HEAP_FULL;
      end else begin
         a_ok = 1'b1;
         a_addr = top_ff + HDR;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      count_in = count_ff;
      top_in = top_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      l_found_in = l_found_ff;
      l_idx_in = l_idx_ff;
      l_size_in = l_size_ff;
      l_pf_in = l_pf_ff;
      l_nf_in = l_nf_ff;
      pre_size_in = pre_size_ff;
      nxt_size_in = nxt_size_ff;
      prev_free_in = prev_free_ff;
      prev_size_in = prev_size_ff;
      f_found_in = f_found_ff;
      f_idx_in = f_idx_ff;
      f_start_in = f_start_ff;
      acc_in = acc_ff;
      ndel_in = ndel_ff;
      del_idx_in = del_idx_ff;
      cell_cmd = '{op: CELL_HOLD, data: '0};
      cell_idx = '0;
      rsp_strobe = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               rsp_in = '0;
               step_in = '0;
               l_found_in = 1'b0;
               f_found_in = 1'b0;
               prev_free_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cell_cmd.op = CELL_ROTATE;
            if (entry_valid && !l_found_ff && ((head0.start + HDR) == req_ff.address)) begin
               l_found_in = 1'b1;
               l_idx_in = step_ff[IW-1:0];
               l_size_in = head0.size;
               l_pf_in = (step_ff != '0) && prev_free_ff;
               pre_size_in = prev_size_ff;
               l_nf_in = next_valid && head1.free;
               nxt_size_in = head1.size;
            end
            if (entry_valid && !f_found_ff && head0.free && (head0.size >= req_ff.size)) begin
               f_found_in = 1'b1;
               f_idx_in = step_ff[IW-1:0];
               f_start_in = head0.start;
            end
            prev_free_in = head0.free;
            prev_size_in = head0.size;
            step_in = step_ff + {{(CW-1){1'b0}}, 1'b1};
            if (step_ff == LAST_STEP) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            if (need_alloc && a_ok) begin
               if (f_found_ff) begin
                  cell_cmd.op = CELL_MARK;
                  cell_cmd.data.free = 1'b0;
                  cell_idx = f_idx_ff;
               end else begin
                  cell_cmd.op = CELL_LOAD;
                  cell_cmd.data = '{start: top_ff, size: req_ff.size, free: 1'b0};
                  cell_idx = count_ff[IW-1:0];
                  count_in = count_ff + {{(CW-1){1'b0}}, 1'b1};
                  top_in = heap_end[31:0];
               end
            end
            if (alloc_req) begin
               rsp_in.result_address = a_addr;
               rsp_in.status = a_status;
            end else if (free_req) begin
               if (req_ff.address == '0) begin
                  rsp_in.status = STATUS_OK;
               end else if (!l_found_ff) begin
                  rsp_in.status = STATUS_UNKNOWN;
               end else begin
                  state_in = S_FREE1;
               end
            end else if (re_req) begin
               if (!l_found_ff) begin
                  rsp_in.status = STATUS_UNKNOWN;
               end else if (l_size_ff >= req_ff.size) begin
                  rsp_in.result_address = req_ff.address;
               end else if (a_ok) begin
                  rsp_in.result_address = a_addr;
                  rsp_in.copy_from = req_ff.address;
                  rsp_in.copy_bytes = l_size_ff;
                  if (f_found_ff && (f_idx_ff == (l_idx_ff - {{(IW-1){1'b0}}, 1'b1}))) begin
                     l_pf_in = 1'b0;
                  end
                  if (f_found_ff && (f_idx_ff == (l_idx_ff + {{(IW-1){1'b0}}, 1'b1}))) begin
                     l_nf_in = 1'b0;
                  end
                  state_in = S_FREE1;
               end else begin
                  rsp_in.status = a_status;
               end
            end
         end
         S_FREE1: begin
            acc_in = l_nf_ff ? (l_size_ff + HDR + nxt_size_ff) : l_size_ff;
            state_in = S_FREE2;
         end
         S_FREE2: begin
            if (l_pf_ff) begin
               acc_in = pre_size_ff + HDR + acc_ff;
            end
            ndel_in = {1'b0, l_pf_ff} + {1'b0, l_nf_ff};
            del_idx_in = l_idx_ff + {{(IW-1){1'b0}}, 1'b1};
            if (l_pf_ff) begin
               del_idx_in = l_idx_ff;
            end
            state_in = S_MERGE;
         end
         S_MERGE: begin
            cell_cmd.op = CELL_MERGE;
            cell_cmd.data.size = acc_ff;
            cell_idx = l_pf_ff ? (l_idx_ff - {{(IW-1){1'b0}}, 1'b1}) : l_idx_ff;
            state_in = (ndel_ff == 2'd0) ? S_DONE : S_CLOSE;
         end
         S_CLOSE: begin
            cell_cmd.op = CELL_CLOSE;
            cell_idx = del_idx_ff;
            count_in = count_ff - {{(CW-1){1'b0}}, 1'b1};
            ndel_in = ndel_ff - 2'd1;
            if (ndel_ff == 2'd1) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_strobe = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_data = rsp_ff;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import ffsa_pkg::*;

   localparam int SEGS = 64;
   localparam int HDR  = 24;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   first_fit_segment_allocator_core #(.MAX_SEGMENTS(SEGS), .HEADER_BYTES(HDR)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   localparam logic [2:0] ADDR_HEAP_LIMIT = 3'd0;
   localparam logic [2:0] ADDR_UNUSED     = 3'd4;
   localparam logic [1:0] KIND_NONE       = 2'd3;

   logic [31:0] seg_start [SEGS];
   logic [31:0] seg_size [SEGS];
   logic        seg_free [SEGS];
   int          seg_count;
   logic [31:0] heap_top;
   logic [31:0] heap_limit;
   logic [31:0] last_grant;

   rsp_type     pending_rsp[$];
   bit          failed;
   int          sender_idle_pct;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int find_segment(logic [31:0] address);
      for (int i = 0; i < seg_count; i++) begin
         if (seg_start[i] + HDR == address) return i;
      end
      return -1;
   endfunction

   function automatic logic [31:0] grant_segment(logic [31:0] size, output logic [2:0] status);
      longint unsigned new_top;
      if (size == 0) begin
         status = STATUS_ZERO_SIZE;
         return 0;
      end
      for (int i = 0; i < seg_count; i++) begin
         if (seg_free[i] && seg_size[i] >= size) begin
            seg_free[i] = 1'b0;
            status = STATUS_OK;
            return seg_start[i] + HDR;
         end
      end
      if (seg_count >= SEGS) begin
         status = STATUS_TABLE_FULL;
         return 0;
      end
      new_top = longint'(heap_top) + HDR + longint'(size);
      if (new_top > longint'(heap_limit)) begin
         status = STATUS_HEAP_FULL;
         return 0;
      end
      seg_start[seg_count] = heap_top;
      seg_size[seg_count] = size;
      seg_free[seg_count] = 1'b0;
      seg_count++;
      heap_top = new_top[31:0];
      status = STATUS_OK;
      return seg_start[seg_count - 1] + HDR;
   endfunction

   function automatic logic [2:0] release_segment(logic [31:0] address);
      int i;
      int k;
      if (address == 0) return STATUS_OK;
      i = find_segment(address);
      if (i < 0) return STATUS_UNKNOWN;
      seg_free[i] = 1'b1;
      k = 0;
      while (k + 1 < seg_count) begin
         if (seg_free[k] && seg_free[k + 1]) begin
            seg_size[k] = seg_size[k] + HDR + seg_size[k + 1];
            for (int j = k + 1; j + 1 < seg_count; j++) begin
               seg_start[j] = seg_start[j + 1];
               seg_size[j] = seg_size[j + 1];
               seg_free[j] = seg_free[j + 1];
            end
            seg_count--;
         end else begin
            k++;
         end
      end
      return STATUS_OK;
   endfunction

   function automatic rsp_type serve_request(req_type r);
      rsp_type     o;
      int          i;
      logic [31:0] fresh;
      logic [31:0] old_size;
      o = '0;
      o.status = STATUS_OK;
      case (r.kind)
         KIND_ALLOC: begin
            o.result_address = grant_segment(r.size, o.status);
         end
         KIND_FREE: begin
            o.status = release_segment(r.address);
         end
         KIND_REALLOC: begin
            if (r.address == 0) begin
               o.result_address = grant_segment(r.size, o.status);
            end else if (r.size == 0) begin
               o.status = release_segment(r.address);
            end else begin
               i = find_segment(r.address);
               if (i < 0) begin
                  o.status = STATUS_UNKNOWN;
               end else if (seg_size[i] >= r.size) begin
                  o.result_address = r.address;
               end else begin
                  old_size = seg_size[i];
                  fresh = grant_segment(r.size, o.status);
                  if (o.status == STATUS_OK) begin
                     o.result_address = fresh;
                     o.copy_from = r.address;
                     o.copy_bytes = old_size < r.size ? old_size : r.size;
                     void'(release_segment(r.address));
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (o.result_address != 0) last_grant = o.result_address;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected transaction, actual %h", $time, rsp_data);
            failed = 1'b1;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.result_address !== want.result_address) begin
               $display("%0t: result_address expected %h actual %h", $time,
                        want.result_address, rsp_data.result_address);
               failed = 1'b1;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_data.status);
               failed = 1'b1;
            end
            if (rsp_data.copy_from !== want.copy_from) begin
               $display("%0t: copy_from expected %h actual %h", $time, want.copy_from,
                        rsp_data.copy_from);
               failed = 1'b1;
            end
            if (rsp_data.copy_bytes !== want.copy_bytes) begin
               $display("%0t: copy_bytes expected %h actual %h", $time, want.copy_bytes,
                        rsp_data.copy_bytes);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic issue(req_type r, bit typed, rsp_type typed_rsp);
      rsp_type p;
      int      gap;
      @(negedge clock);
      start = 1'b1;
      req_data = r;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = serve_request(r);
      if (typed) p = typed_rsp;
      pending_rsp = {pending_rsp, p};
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain;
      @(negedge clock);
      start = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      drain();
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = addr;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == ADDR_HEAP_LIMIT) heap_limit = value;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   function automatic req_type random_request();
      req_type r;
      int      pick;
      int      idx;
      r.kind = KIND_ALLOC;
      r.address = 0;
      r.size = $urandom_range(1, 256);
      pick = $urandom_range(99);
      if (pick < 5) begin
         r.size = $urandom();
      end else if (pick < 50) begin
      end else if (pick < 90 && seg_count > 0) begin
         idx = $urandom_range(seg_count - 1);
         r.address = seg_start[idx] + HDR;
         if (pick < 72) begin
            r.kind = KIND_FREE;
         end else begin
            r.kind = KIND_REALLOC;
            r.size = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 600);
         end
      end else begin
         r.kind = 2'($urandom_range(3));
         r.address = ($urandom_range(3) == 0) ? 32'd0 : $urandom();
         r.size = ($urandom_range(3) == 0) ? 32'd0 : $urandom();
      end
      return r;
   endfunction

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [31:0] size;
      bit          use_last;
      bit          typed;
      rsp_type     want;
   } row_type;

   row_type directed [] = '{
      '{KIND_ALLOC,   0,            0,            0, 1, '{0,  STATUS_ZERO_SIZE, 0, 0}},
      '{KIND_FREE,    0,            0,            0, 1, '{0,  STATUS_OK, 0, 0}},
      '{KIND_ALLOC,   0,            100,          0, 1, '{24, STATUS_OK, 0, 0}},
      '{KIND_ALLOC,   0,            32'hFFFFFFFF, 0, 1, '{0,  STATUS_HEAP_FULL, 0, 0}},
      '{KIND_FREE,    12345,        0,            0, 1, '{0,  STATUS_UNKNOWN, 0, 0}},
      '{KIND_REALLOC, 0,            50,           0, 1, '{148, STATUS_OK, 0, 0}},
      '{KIND_REALLOC, 24,           60,           0, 1, '{24, STATUS_OK, 0, 0}},
      '{KIND_NONE,    32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1, '{0,  STATUS_OK, 0, 0}},
      '{KIND_REALLOC, 9999,         5,            0, 1, '{0,  STATUS_UNKNOWN, 0, 0}},
      '{KIND_REALLOC, 24,           200,          0, 0, '{0, 0, 0, 0}},
      '{KIND_FREE,    148,          0,            0, 0, '{0, 0, 0, 0}},
      '{KIND_ALLOC,   0,            10,           0, 0, '{0, 0, 0, 0}},
      '{KIND_FREE,    0,            0,            1, 0, '{0, 0, 0, 0}},
      '{KIND_FREE,    0,            0,            1, 0, '{0, 0, 0, 0}},
      '{KIND_ALLOC,   0,            300,          0, 0, '{0, 0, 0, 0}},
      '{KIND_REALLOC, 0,            0,            1, 0, '{0, 0, 0, 0}},
      '{KIND_ALLOC,   0,            40,           0, 0, '{0, 0, 0, 0}},
      '{KIND_REALLOC, 0,            65000,        1, 0, '{0, 0, 0, 0}},
      '{KIND_REALLOC, 0,            80,           1, 0, '{0, 0, 0, 0}},
      '{KIND_ALLOC,   0,            65000,        0, 0, '{0, 0, 0, 0}}
   };

   logic [31:0] phase_limit [] = '{32'd0, 32'hFFFFFFFF, 32'd4000, 32'd65536, 32'd20000};

   initial begin
      req_type r;
      failed = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      sender_idle_pct = 0;
      seg_count = 0;
      heap_top = 0;
      heap_limit = HEAP_LIMIT_RESET;
      last_grant = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[n]) begin
         r.kind = directed[n].kind;
         r.address = directed[n].use_last ? last_grant : directed[n].address;
         r.size = directed[n].size;
         issue(r, directed[n].typed, directed[n].want);
      end

      csr_write(ADDR_UNUSED, 32'd0);
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(ADDR_HEAP_LIMIT, phase_limit[ph]);
         for (int n = 0; n < 345; n++) begin
            case ((n / 60) % 4)
               0: sender_idle_pct = 0;
               1: sender_idle_pct = 65;
               2: sender_idle_pct = 22;
               default: sender_idle_pct = 5;
            endcase
            if (n == 170) drain();
            issue(random_request(), 1'b0, '0);
         end
      end

      drain();
      if (!failed) begin
         $display("** first_fit_segment_allocator_core: PASSED **");
      end else begin
         $display("** first_fit_segment_allocator_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("** first_fit_segment_allocator_core: FAILED **");
      $finish;
   end

endmodule
